/* design/flcp_pkg.sv */
// ============================================================================
// flcp_pkg: shared types and constants of the fixed-length code packer
// Field widths, item mode codes, table geometry and the merge result struct.
// ============================================================================
package flcp_pkg;

    localparam int SYM_W       = 8;
    localparam int CODE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int FILL_W      = 3;
    localparam int MODE_W      = 2;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;
    localparam logic [LEN_W-1:0] LEN_MIN   = 4'd1;
    localparam logic [LEN_W-1:0] LEN_MAX   = 4'd8;

    // Item modes. The fourth encoding is unused and ignored.
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2
    } t_mode;

    // Result of appending one code to the byte buffer.
    typedef struct packed {
        logic              full;       // a whole byte completed
        logic [CODE_W-1:0] out_byte;   // completed byte, valid when full
        logic [CODE_W-1:0] buf_next;   // buffer contents afterwards
        logic [FILL_W-1:0] fill_next;  // bits held afterwards
    } t_merge;

endpackage

/* design/flcp_in_if.sv */
// ============================================================================
// flcp_in_if: request channel into the code packer
// Carries one load, encode or flush request with a valid/ready handshake.
// ============================================================================
interface flcp_in_if;
    import flcp_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_value;

    modport source (output valid, output mode, output symbol, output code_value,
                    input ready);
    modport sink   (input valid, input mode, input symbol, input code_value,
                    output ready);
endinterface

/* design/flcp_out_if.sv */
// ============================================================================
// flcp_out_if: result channel out of the code packer
// Carries one packed byte, its meaningful bit count and an error flag.
// ============================================================================
interface flcp_out_if;
    import flcp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] packed_byte;
    logic [LEN_W-1:0]  valid_bits;
    logic              error;

    modport source (output valid, output packed_byte, output valid_bits,
                    output error, input ready);
    modport sink   (input valid, input packed_byte, input valid_bits,
                    input error, output ready);
endinterface

/* design/flcp_ram.sv */
// ============================================================================
// flcp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ============================================================================
module flcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/flcp_merge.sv */
// ============================================================================
// flcp_merge: appends one code to the partial byte buffer
// Masks the code to its length, places it below the held bits in a 16-bit
// window and splits off a completed byte when eight or more bits are held.
// ============================================================================
module flcp_merge (
    input  logic [flcp_pkg::CODE_W-1:0] i_buf,
    input  logic [flcp_pkg::FILL_W-1:0] i_fill,
    input  logic [flcp_pkg::CODE_W-1:0] i_code,
    input  logic [flcp_pkg::LEN_W-1:0]  i_len,
    output flcp_pkg::t_merge            o_res
);
    import flcp_pkg::*;

    logic [CODE_W-1:0]   mask;
    logic [CODE_W-1:0]   code_masked;
    logic [4:0]          shift;
    logic [2*CODE_W-1:0] window;
    logic [LEN_W-1:0]    total;

    always_comb begin
        // The length is already limited to 1..8, so the shift stays within 0..7.
        mask        = 8'hFF >> (4'd8 - i_len);
        code_masked = i_code & mask;
        // Held bits sit at the top of the window; the new code goes right below.
        shift       = 5'd16 - 5'(i_fill) - 5'(i_len);
        window      = {i_buf, 8'h00} | (16'(code_masked) << shift);
        total       = 4'(i_fill) + i_len;

        o_res.full = total >= 4'd8;
        o_res.out_byte = window[15:8];
        if (o_res.full) begin
            o_res.buf_next  = window[7:0];
            o_res.fill_next = 3'(total - 4'd8);
        end else begin
            o_res.buf_next  = window[15:8];
            o_res.fill_next = total[FILL_W-1:0];
        end
    end
endmodule

/* design/fixed_length_code_packer_core.sv */
// ============================================================================
// fixed_length_code_packer_core: fixed-length code bit packer
// Maps byte symbols to 1..8 bit codes through a loadable table and packs the
// codes, first bit in bit 7, into a stream of bytes.
// ============================================================================
// The block takes one request per clock cycle while ready is high and gives
// its result, if any, in the output register. A load request writes the code
// table entry for its symbol and marks it loaded. An encode request appends
// the low code_length bits of the symbol's code to the byte buffer, most
// significant bit first, and yields one byte with valid_bits 8 each time a
// byte completes; encoding a symbol that was never loaded yields one result
// with error set, packed_byte 0 and valid_bits 0, and leaves the buffer alone.
// A flush request emits the partial byte, zero padded, with valid_bits equal
// to the number of held bits, and yields nothing when the buffer is empty.
// The table sits in a 256-entry RAM with a registered read, so a request moves
// through the stages in order: the first reads the entry, the second merges the
// code into the buffer and loads the output register. Both stages advance
// every cycle as long as results are taken, so the sustained rate is one
// request per cycle; ready drops only while a finished result waits and the
// second stage holds a request behind it. code_length may be written only
// while no request is in flight; 0 behaves as 1 and 9..15 behave as 8.
// ============================================================================
module fixed_length_code_packer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [flcp_pkg::LEN_W-1:0] i_cfg_wdata,
    flcp_in_if.sink                    i_in,
    flcp_out_if.source                 o_out
);
    import flcp_pkg::*;

    // Configuration register.
    logic [LEN_W-1:0] r_code_length;

    // One loaded flag per table entry, cleared at reset.
    logic [TABLE_DEPTH-1:0] r_loaded;
    logic [TABLE_DEPTH-1:0] n_loaded;

    // Second stage: the request that waits for its table data.
    logic              r_s1_valid;
    logic [MODE_W-1:0] r_s1_mode;
    logic              r_s1_loaded;

    // Byte buffer state.
    logic [CODE_W-1:0] r_buf;
    logic [FILL_W-1:0] r_fill;
    logic [CODE_W-1:0] n_buf;
    logic [FILL_W-1:0] n_fill;

    // Output register.
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_byte;
    logic [LEN_W-1:0]  r_out_bits;
    logic              r_out_err;
    logic              n_out_valid;
    logic [CODE_W-1:0] n_out_byte;
    logic [LEN_W-1:0]  n_out_bits;
    logic              n_out_err;

    logic              in_accept;
    logic              s1_adv;
    logic              s1_fire;
    logic              tbl_we;
    logic              tbl_re;
    logic [CODE_W-1:0] tbl_rdata;
    logic [LEN_W-1:0]  eff_len;
    t_merge            merge;

    // The second stage moves on whenever the output register is free or is
    // being emptied in this cycle; a new request enters behind it.
    assign s1_adv     = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in.valid && i_in.ready;

    // Table writes happen on acceptance of a load; reads on acceptance of an
    // encode. A request that follows a load of the same entry in the next
    // cycle reads the new code, since the write lands at the earlier edge.
    assign tbl_we = in_accept && (i_in.mode == MODE_LOAD);
    assign tbl_re = in_accept && (i_in.mode == MODE_ENCODE);

    flcp_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_in.symbol),
        .i_wdata (i_in.code_value),
        .i_re    (tbl_re),
        .i_raddr (i_in.symbol),
        .o_rdata (tbl_rdata)
    );

    // Out-of-range lengths are clamped to the nearest legal value.
    always_comb begin
        if (r_code_length < LEN_MIN) begin
            eff_len = LEN_MIN;
        end else if (r_code_length > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_code_length;
        end
    end

    flcp_merge u_merge (
        .i_buf  (r_buf),
        .i_fill (r_fill),
        .i_code (tbl_rdata),
        .i_len  (eff_len),
        .o_res  (merge)
    );

    always_comb begin
        n_loaded = r_loaded;
        if (tbl_we) begin
            n_loaded[i_in.symbol] = 1'b1;
        end
    end

    // Second-stage work: decide the result and the new buffer state.
    always_comb begin
        n_buf       = r_buf;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_bits  = r_out_bits;
        n_out_err   = r_out_err;
        if (s1_fire) begin
            case (r_s1_mode)
                MODE_ENCODE: begin
                    if (!r_s1_loaded) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                        n_out_bits  = '0;
                        n_out_err   = 1'b1;
                    end else begin
                        n_buf  = merge.buf_next;
                        n_fill = merge.fill_next;
                        if (merge.full) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = merge.out_byte;
                            n_out_bits  = LEN_MAX;
                            n_out_err   = 1'b0;
                        end
                    end
                end
                MODE_FLUSH: begin
                    if (r_fill != '0) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = r_buf;
                        n_out_bits  = 4'(r_fill);
                        n_out_err   = 1'b0;
                        n_buf       = '0;
                        n_fill      = '0;
                    end
                end
                default: begin
                    // Loads finished at acceptance; the unused mode does nothing.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length <= LEN_RESET;
            r_loaded      <= '0;
            r_s1_valid    <= 1'b0;
            r_buf         <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_code_length <= i_cfg_wdata;
            end
            r_loaded    <= n_loaded;
            r_s1_valid  <= in_accept || (r_s1_valid && !s1_adv);
            r_buf       <= n_buf;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_mode   <= i_in.mode;
            r_s1_loaded <= r_loaded[i_in.symbol];
        end
        r_out_byte <= n_out_byte;
        r_out_bits <= n_out_bits;
        r_out_err  <= n_out_err;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.packed_byte = r_out_byte;
    assign o_out.valid_bits  = r_out_bits;
    assign o_out.error       = r_out_err;

`ifndef NO_ASSERTIONS
    // An error result never carries data bits.
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_bits == '0 && r_out_byte == '0))
        else $error("error result carries data bits");

    // A good result always carries at least one meaningful bit.
    a_bits_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_err) |-> (r_out_bits != '0))
        else $error("data result with no valid bits");

    // A stalled result with a request behind it must hold off the input.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while the pipeline is blocked");

    // Encoding an unloaded symbol leaves the buffer untouched.
    a_unloaded_keeps_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_mode == MODE_ENCODE && !r_s1_loaded)
            |=> ($stable(r_buf) && $stable(r_fill)))
        else $error("buffer changed on an unloaded symbol");
`endif

endmodule

/* tb/sv/tb_fixed_length_code_packer_core.sv */
// ============================================================================
// tb_fixed_length_code_packer_core: self-checking bench of the code packer
// Drives load, encode and flush requests through the request channel under
// random bursts and gaps, predicts every packed byte, error and partial flush
// in a bench-side copy of the table and buffer, and compares each result
// taken from the result channel while the receiver stalls on its own pattern.
// ============================================================================
module tb_fixed_length_code_packer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import flcp_pkg::*;

    // The fourth mode encoding has no package name; the block must ignore it.
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;
    localparam logic [LEN_W-1:0]  FULL_BYTE_BITS = 4'd8;

    // Requests pass through the second stage before the output register, so a handful of
    // quiet cycles after the last result covers requests that yield nothing.
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 32;
    localparam int HOLD_ITEMS     = 60;
    localparam int NUM_PHASES     = 12;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_value;
    } t_request;

    typedef struct packed {
        logic [CODE_W-1:0] data;
        logic [LEN_W-1:0]  nbits;
        logic              err;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              cfg_we    = 1'b0;
    logic [LEN_W-1:0]  cfg_wdata = LEN_RESET;

    logic              drv_valid = 1'b0;
    t_request          drv_req   = '0;
    logic              rx_ready  = 1'b0;

    flcp_in_if  in_if ();
    flcp_out_if out_if ();

    assign in_if.valid      = drv_valid;
    assign in_if.mode       = drv_req.mode;
    assign in_if.symbol     = drv_req.symbol;
    assign in_if.code_value = drv_req.code_value;
    assign out_if.ready     = rx_ready;

    fixed_length_code_packer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench-side copy of the packer state. It advances once per accepted
    // request, in the order the block accepts them, so the expected bytes
    // come out in the same order the block must produce them.
    // ------------------------------------------------------------------------
    logic [CODE_W-1:0] code_copy   [TABLE_DEPTH];
    logic              loaded_copy [TABLE_DEPTH];
    logic [CODE_W-1:0] buf_copy  = '0;
    logic [FILL_W-1:0] fill_copy = '0;
    logic [LEN_W-1:0]  len_copy  = LEN_RESET;

    t_result  expected_bytes [$];
    t_request pending_requests [$];

    // Stimulus-side view of which symbols have been loaded, so that most
    // encode requests hit a real code and get deep into the buffer logic.
    logic           gen_loaded [TABLE_DEPTH];
    logic [SYM_W-1:0] gen_loaded_syms [$];

    int failures       = 0;
    int accepted_reqs  = 0;
    int results_seen   = 0;
    int error_results  = 0;
    int partial_flushes = 0;
    int settings_used  = 1;

    // Phase controls, written by the stimulus process at falling edges only.
    logic steady_phase = 1'b0;
    logic hold_request = 1'b0;

    function automatic void pack_code(input t_request r);
        int             eff;
        int             fill;
        int             total;
        logic [15:0]    code16;
        logic [15:0]    window;
        t_result        res;
        eff  = int'(len_copy);
        if (eff < int'(LEN_MIN)) eff = int'(LEN_MIN);
        if (eff > int'(LEN_MAX)) eff = int'(LEN_MAX);
        fill = int'(fill_copy);
        case (r.mode)
            MODE_LOAD: begin
                code_copy[r.symbol]   = r.code_value;
                loaded_copy[r.symbol] = 1'b1;
            end
            MODE_ENCODE: begin
                if (!loaded_copy[r.symbol]) begin
                    // Unknown symbol: error result, buffer left as it was.
                    res = '{data: '0, nbits: '0, err: 1'b1};
                    expected_bytes = {expected_bytes, res};
                end else begin
                    // Held bits sit at the top of a 16-bit window and the new
                    // code lands right below them, first code bit highest.
                    code16 = {8'h00, code_copy[r.symbol]} & ((16'd1 << eff) - 16'd1);
                    window = {buf_copy, 8'h00} | (code16 << (16 - fill - eff));
                    total  = fill + eff;
                    if (total >= 8) begin
                        res = '{data: window[15:8], nbits: FULL_BYTE_BITS, err: 1'b0};
                        expected_bytes = {expected_bytes, res};
                        buf_copy  = window[7:0];
                        fill_copy = FILL_W'(total - 8);
                    end else begin
                        buf_copy  = window[15:8];
                        fill_copy = FILL_W'(total);
                    end
                end
            end
            MODE_FLUSH: begin
                // An empty buffer flushes to nothing.
                if (fill_copy != '0) begin
                    res = '{data: buf_copy, nbits: {1'b0, fill_copy}, err: 1'b0};
                    expected_bytes = {expected_bytes, res};
                    buf_copy  = '0;
                    fill_copy = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_request(input logic [MODE_W-1:0] mode,
                                          input logic [SYM_W-1:0]  sym,
                                          input logic [CODE_W-1:0] val);
        t_request r;
        r = '{mode: mode, symbol: sym, code_value: val};
        if (mode == MODE_LOAD && !gen_loaded[sym]) begin
            gen_loaded[sym] = 1'b1;
            gen_loaded_syms = {gen_loaded_syms, sym};
        end
        pending_requests = {pending_requests, r};
    endfunction

    // Mostly encodes of loaded symbols, with loads, flushes, unknown symbols
    // and the odd request in the unused mode mixed in.
    function automatic void queue_random_request();
        int               pick;
        logic [SYM_W-1:0] sym;
        pick = $urandom_range(0, 99);
        sym  = SYM_W'($urandom_range(0, 255));
        if (pick < 14) begin
            queue_request(MODE_LOAD, sym, CODE_W'($urandom_range(0, 255)));
        end else if (pick < 80) begin
            if (gen_loaded_syms.size() > 0 && $urandom_range(0, 99) < 85)
                sym = gen_loaded_syms[$urandom_range(0, gen_loaded_syms.size() - 1)];
            queue_request(MODE_ENCODE, sym, CODE_W'($urandom_range(0, 255)));
        end else if (pick < 96) begin
            queue_request(MODE_FLUSH, sym, CODE_W'($urandom_range(0, 255)));
        end else begin
            queue_request(MODE_UNUSED, sym, CODE_W'($urandom_range(0, 255)));
        end
    endfunction

    // Waits until the driver has nothing left, every expected result has come
    // back, and requests without a result have had time to leave the pipe.
    task automatic drain_packer();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || drv_valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // The block is idle whenever this runs, so the predictor can take the new
    // length at once.
    task automatic write_code_length(input logic [LEN_W-1:0] len);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        len_copy   = len;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: sends pending requests in bursts of random length with random
    // gaps between them. A request that was offered stays on the channel
    // until it is taken, and the predictor runs at the edge that takes it.
    // ------------------------------------------------------------------------
    t_request next_req;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_if.ready) begin
                pack_code(drv_req);
                accepted_reqs++;
            end
            if (!drv_valid || in_if.ready) begin
                if (gap_left > 0 && !steady_phase) begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    next_req = pending_requests.pop_front();
                    drv_req   <= next_req;
                    drv_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every taken result against the oldest expectation.
    // Its ready follows a pattern of its own: runs of ready separated by
    // short stalls, always ready in a steady phase, and once a long hold-off
    // that it counts out itself so the block backs up into its input.
    // ------------------------------------------------------------------------
    int   rx_left     = 0;
    logic hold_started = 1'b0;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (out_if.valid && rx_ready) begin
                results_seen++;
                if (out_if.error) error_results++;
                if (!out_if.error && out_if.valid_bits != FULL_BYTE_BITS) partial_flushes++;
                if (expected_bytes.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result: actual byte %h bits %0d err %0b",
                             $realtime, out_if.packed_byte, out_if.valid_bits, out_if.error);
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_if.packed_byte !== want.data || out_if.valid_bits !== want.nbits ||
                        out_if.error !== want.err) begin
                        failures++;
                        $display("%0t: result mismatch: expected byte %h bits %0d err %0b, %s",
                                 $realtime, want.data, want.nbits, want.err, "actual follows");
                        $display("%0t:                  actual   byte %h bits %0d err %0b",
                                 $realtime, out_if.packed_byte, out_if.valid_bits,
                                 out_if.error);
                    end
                end
            end
            if (hold_request && !hold_started) begin
                hold_started = 1'b1;
                rx_left      = LONG_HOLD;
                rx_ready    <= 1'b0;
            end else if (rx_left > 0) begin
                rx_left--;
            end else if (steady_phase) begin
                rx_ready <= 1'b1;
            end else if (rx_ready) begin
                rx_ready <= 1'b0;
                rx_left   = $urandom_range(0, 4);
            end else begin
                rx_ready <= 1'b1;
                rx_left   = $urandom_range(0, 30);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a healthy run never goes long without taking a request or a
    // result; the longest quiet stretch is the receiver's long hold-off.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((drv_valid && in_if.ready) || (out_if.valid && rx_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed part at the reset length and at length 3, then
    // random phases, each under its own code length. Lengths are changed
    // only once the block has drained.
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0] len_plan [NUM_PHASES] = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd4, 4'd7,
                                                4'd5, 4'd9, 4'd6, 4'd8, 4'd3, 4'd12};

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            code_copy[i]   = '0;
            loaded_copy[i] = 1'b0;
            gen_loaded[i]  = 1'b0;
        end

        // Reset length of 8: unknown symbol, empty flush, unused mode, codes of
        // all ones and all zeros, and a second unknown symbol after bytes.
        queue_request(MODE_ENCODE, 8'h00, 8'h00);
        queue_request(MODE_FLUSH,  8'h00, 8'h00);
        queue_request(MODE_UNUSED, 8'hFF, 8'hFF);
        queue_request(MODE_LOAD,   8'h00, 8'hFF);
        queue_request(MODE_LOAD,   8'hFF, 8'h00);
        queue_request(MODE_LOAD,   8'h80, 8'h5A);
        queue_request(MODE_ENCODE, 8'h00, 8'h00);
        queue_request(MODE_ENCODE, 8'hFF, 8'hFF);
        queue_request(MODE_ENCODE, 8'h80, 8'h00);
        queue_request(MODE_ENCODE, 8'h7F, 8'h00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_packer();

        // Length 3: code bits above the length are dropped, an unknown symbol
        // leaves held bits alone, a partial flush pads with zeros, and a code
        // that straddles a byte boundary leaves one bit for the last flush.
        write_code_length(4'd3);
        settings_used++;
        queue_request(MODE_LOAD,   8'h01, 8'hFD);
        queue_request(MODE_ENCODE, 8'h01, 8'h00);
        queue_request(MODE_ENCODE, 8'h42, 8'h00);
        queue_request(MODE_FLUSH,  8'h00, 8'h00);
        queue_request(MODE_ENCODE, 8'h01, 8'h00);
        queue_request(MODE_ENCODE, 8'h01, 8'h00);
        queue_request(MODE_ENCODE, 8'h01, 8'h00);
        queue_request(MODE_FLUSH,  8'h00, 8'h00);
        drain_packer();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_code_length(len_plan[p]);
            settings_used++;
            steady_phase = (p == 2);
            if (p == 4) begin
                // Plenty of requests queued so the sender keeps offering
                // through the receiver's long hold-off.
                for (int k = 0; k < HOLD_ITEMS; k++) queue_random_request();
                hold_request = 1'b1;
            end else begin
                for (int k = 0; k < PHASE_ITEMS; k++) queue_random_request();
            end
            // The sender pauses here until every expected result has come.
            drain_packer();
        end

        $display("Ran %0d requests under %0d code length settings.",
                 accepted_reqs, settings_used);
        $display("Checked %0d results: %0d errors, %0d partial flushes.",
                 results_seen, error_results, partial_flushes);
        if (failures == 0 && expected_bytes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
